[rtl/bpu_pkg.sv]
// Shared types and constants for the bitmap pixel row unpacker.
package bpu_pkg;

    // Field and register widths
    localparam int DATA_W     = 8;
    localparam int IMG_DIM_W  = 13;
    localparam int PCNT_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int COLOR_W    = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_PALETTE_COUNT
    } cfg_index_t;

    // Bits per pixel codes
    typedef enum logic [1:0] {
        FMT_1BPP,
        FMT_4BPP,
        FMT_8BPP,
        FMT_24BPP
    } pixel_format_t;

    // One raw input byte
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              frame_start;
    } byte_item_t;

    // One output pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       image_end;
        logic       last_of_item;
    } pixel_item_t;

endpackage

[rtl/bpu_byte_if.sv]
// Valid/ready channel carrying raw input bytes.
interface bpu_byte_if
    import bpu_pkg::*;
();
    logic       valid;
    logic       ready;
    byte_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/bpu_pixel_if.sv]
// Valid/ready channel carrying unpacked RGB pixels.
interface bpu_pixel_if
    import bpu_pkg::*;
();
    logic        valid;
    logic        ready;
    pixel_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/bitmap_pixel_row_unpacker_core.sv]
// Bitmap palette loader and pixel row unpacker, top level.
//
//  Channel    Dir  Transaction
//  byte_ch    in   one raw byte of palette or pixel data, plus frame_start
//  pixel_ch   out  one RGB pixel with row_end / image_end / last_of_item
//  cfg_*      in   register write: cfg_write, cfg_index, cfg_data
//
//  Steps: a palette byte or a byte after the image passes the idle and phase
//  states; a pixel data byte also passes decode, then the emit step per pixel.
//  One pixel per cycle, output allowing, set by the single read port (registered).
//  Reset: palette entries read as zero until written (per-entry valid bits),
//  so no clearing pass is needed; the block is ready right after reset.
//  Stalls: a full output register holds the sequencer in its emit step; a
//  finished pixel may wait at the output while the next byte is taken.
module bitmap_pixel_row_unpacker_core
    import bpu_pkg::*;
#(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bpu_byte_if.sink              byte_ch,
    bpu_pixel_if.source           pixel_ch
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int RBW    = $clog2(3 * MAX_WIDTH + 4);
    localparam int CWW    = (WW > IMG_DIM_W) ? WW : IMG_DIM_W;
    localparam int CHW    = (HW > IMG_DIM_W) ? HW : IMG_DIM_W;
    localparam int PIDX_W = $clog2(PALETTE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_PHASE, S_PIXEL, S_PUT} state_t;
    typedef enum logic [1:0] {PH_LOAD, PH_PIXELS, PH_DONE} phase_t;

    // Configuration registers and derived row geometry
    pixel_format_t        fmt_reg;
    logic [IMG_DIM_W-1:0] width_reg;
    logic [IMG_DIM_W-1:0] height_reg;
    logic [PCNT_W-1:0]    pcount_reg;
    logic [WW-1:0]        w_eff_reg;
    logic [HW-1:0]        h_eff_reg;
    logic [RBW-1:0]       data_len_reg;
    logic [RBW-1:0]       padded_reg;

    logic [CWW-1:0] w_cfg, w_clamp;
    logic [CHW-1:0] h_cfg, h_clamp;
    logic [RBW-1:0] w_ext, data_len_next, padded_next;

    // Sequencer state
    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [PCNT_W-1:0]      fill_reg, fill_next;
    logic [15:0]            held_reg, held_next;
    logic [RBW-1:0]         rbc_reg, rbc_next;
    logic [1:0]             mod3_reg, mod3_next;
    logic [WW-1:0]          col_reg, col_next;
    logic [HW-1:0]          row_reg, row_next;
    logic [DATA_W-1:0]      byte_reg, byte_next;
    logic [2:0]             slot_reg, slot_next;
    logic                   out_valid_reg, out_valid_next;
    pixel_item_t            out_data_reg, out_data_next;
    logic [PALETTE_DEPTH-1:0] pal_valid_reg, pal_valid_next;

    // Palette memory
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_ok_reg;
    logic [DATA_W-1:0]  rd_idx;
    logic               rd_hit;
    logic               mem_we;
    logic [PIDX_W-1:0]  mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;

    assign byte_ch.ready  = (state_reg == S_IDLE);
    assign pixel_ch.valid = out_valid_reg;
    assign pixel_ch.data  = out_data_reg;

    // Width/height clamp and padded row length
    always_comb
    begin
        w_cfg = CWW'(width_reg);
        h_cfg = CHW'(height_reg);
        if (w_cfg == '0)
            w_clamp = CWW'(1);
        else if (w_cfg > CWW'(MAX_WIDTH))
            w_clamp = CWW'(MAX_WIDTH);
        else
            w_clamp = w_cfg;
        if (h_cfg == '0)
            h_clamp = CHW'(1);
        else if (h_cfg > CHW'(MAX_HEIGHT))
            h_clamp = CHW'(MAX_HEIGHT);
        else
            h_clamp = h_cfg;

        w_ext = RBW'(w_eff_reg);
        unique case (fmt_reg)
            FMT_1BPP:  data_len_next = (w_ext + RBW'(7)) >> 3;
            FMT_4BPP:  data_len_next = (w_ext + RBW'(1)) >> 1;
            FMT_8BPP:  data_len_next = w_ext;
            FMT_24BPP: data_len_next = w_ext + (w_ext << 1);
            default:   data_len_next = w_ext;
        endcase
        padded_next = (data_len_next + RBW'(3)) & ~RBW'(3);
    end

    // Config write port; clamped sizes are registered, then the row lengths from them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_1BPP;
            width_reg    <= IMG_DIM_W'(1);
            height_reg   <= IMG_DIM_W'(1);
            pcount_reg   <= '0;
            w_eff_reg    <= WW'(1);
            h_eff_reg    <= HW'(1);
            data_len_reg <= RBW'(1);
            padded_reg   <= RBW'(4);
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_PIXEL_FORMAT:  fmt_reg    <= pixel_format_t'(cfg_data[1:0]);
                    CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[IMG_DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[IMG_DIM_W-1:0];
                    CFG_PALETTE_COUNT: pcount_reg <= cfg_data[PCNT_W-1:0];
                    default:           pcount_reg <= pcount_reg;
                endcase
            end
            w_eff_reg    <= WW'(w_clamp);
            h_eff_reg    <= HW'(h_clamp);
            data_len_reg <= data_len_next;
            padded_reg   <= padded_next;
        end
    end

    // Sequencer next state
    always_comb
    begin
        logic              do_adv;
        logic              emit;
        logic              rend;
        logic              last;
        logic [WW:0]       col_inc;
        logic [HW:0]       row_inc;
        logic [RBW:0]      rbc_sum;
        logic [COLOR_W-1:0] rgb;

        do_adv         = 1'b0;
        emit           = 1'b0;
        col_inc        = (WW+1)'(col_reg) + (WW+1)'(1);
        row_inc        = (HW+1)'(row_reg) + (HW+1)'(1);
        rbc_sum        = (RBW+1)'(rbc_reg) + (RBW+1)'(1);
        rend           = (col_inc >= (WW+1)'(w_eff_reg));
        last           = rend || (slot_reg == 3'd0);
        rgb            = '0;

        state_next     = state_reg;
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        held_next      = held_reg;
        rbc_next       = rbc_reg;
        mod3_next      = mod3_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        byte_next      = byte_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !pixel_ch.ready;
        out_data_next  = out_data_reg;
        pal_valid_next = pal_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[PIDX_W-1:0];
        mem_wdata      = {byte_reg, held_reg[7:0], held_reg[15:8]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (byte_ch.valid)
                begin
                    byte_next  = byte_ch.data.data_byte;
                    state_next = S_PHASE;
                    if (byte_ch.data.frame_start)
                    begin
                        phase_next = PH_LOAD;
                        fill_next  = '0;
                        held_next  = '0;
                        rbc_next   = '0;
                        mod3_next  = '0;
                        col_next   = '0;
                        row_next   = '0;
                    end
                end
            end

            // Palette loading, hand over to pixel decode, or bytes after the image ignored
            S_PHASE:
            begin
                unique case (phase_reg)
                    PH_LOAD:
                    begin
                        if (fill_reg < pcount_reg)
                        begin
                            unique case (rbc_reg[1:0])
                                2'd0: held_next = {8'h00, byte_reg};
                                2'd1: held_next = {held_reg[7:0], byte_reg};
                                2'd2:
                                begin
                                    if (fill_reg < PCNT_W'(PALETTE_DEPTH))
                                    begin
                                        mem_we = 1'b1;
                                        pal_valid_next[fill_reg[PIDX_W-1:0]] = 1'b1;
                                    end
                                end
                                default: fill_next = fill_reg + PCNT_W'(1);
                            endcase
                            rbc_next   = RBW'(2'(rbc_reg[1:0] + 2'd1));
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_PIXELS;
                            rbc_next   = '0;
                            held_next  = '0;
                            mod3_next  = '0;
                            state_next = S_PIXEL;
                        end
                    end
                    PH_PIXELS: state_next = S_PIXEL;
                    default:   state_next = S_IDLE;
                endcase
            end

            // Decide what this byte yields
            S_PIXEL:
            begin
                if (rbc_reg < data_len_reg)
                begin
                    unique case (fmt_reg)
                        FMT_1BPP:
                        begin
                            emit      = (col_reg < w_eff_reg);
                            slot_next = 3'd7;
                        end
                        FMT_4BPP:
                        begin
                            emit      = (col_reg < w_eff_reg);
                            slot_next = 3'd1;
                        end
                        FMT_8BPP:
                        begin
                            emit      = (col_reg < w_eff_reg);
                            slot_next = 3'd0;
                        end
                        default:
                        begin
                            unique case (mod3_reg)
                                2'd0: held_next = {8'h00, byte_reg};
                                2'd1: held_next = {held_reg[7:0], byte_reg};
                                default:
                                begin
                                    emit      = (col_reg < w_eff_reg);
                                    slot_next = 3'd0;
                                end
                            endcase
                        end
                    endcase
                end
                if (emit)
                    state_next = S_PUT;
                else
                begin
                    do_adv     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // One pixel per cycle into the output register, while it can take one
            S_PUT:
            begin
                if (!out_valid_reg || pixel_ch.ready)
                begin
                    if (fmt_reg == FMT_24BPP)
                        rgb = {byte_reg, held_reg[7:0], held_reg[15:8]};
                    else if (rd_ok_reg)
                        rgb = rd_data_reg;
                    else
                        rgb = '0;
                    out_valid_next             = 1'b1;
                    out_data_next.red          = rgb[23:16];
                    out_data_next.green        = rgb[15:8];
                    out_data_next.blue         = rgb[7:0];
                    out_data_next.row_end      = rend;
                    out_data_next.image_end    = rend && (row_inc >= (HW+1)'(h_eff_reg));
                    out_data_next.last_of_item = last;
                    col_next                   = WW'(col_inc);
                    if (last)
                    begin
                        do_adv     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        slot_next = slot_reg - 3'd1;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // Byte position advance and row wrap
        if (do_adv)
        begin
            if (rbc_sum >= (RBW+1)'(padded_reg))
            begin
                rbc_next  = '0;
                mod3_next = '0;
                col_next  = '0;
                row_next  = HW'(row_inc);
                if (row_inc >= (HW+1)'(h_eff_reg))
                    phase_next = PH_DONE;
            end
            else
            begin
                rbc_next  = RBW'(rbc_sum);
                mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            end
        end
    end

    // Sequencer registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_LOAD;
            fill_reg      <= '0;
            held_reg      <= '0;
            rbc_reg       <= '0;
            mod3_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            byte_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            pal_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            rbc_reg       <= rbc_next;
            mod3_reg      <= mod3_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            byte_reg      <= byte_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            pal_valid_reg <= pal_valid_next;
        end
    end

    // Palette index for the slot being fetched
    always_comb
    begin
        unique case (fmt_reg)
            FMT_1BPP: rd_idx = {7'b0, byte_reg[slot_next]};
            FMT_4BPP: rd_idx = slot_next[0] ? {4'b0, byte_reg[7:4]} : {4'b0, byte_reg[3:0]};
            default:  rd_idx = byte_reg;
        endcase
        rd_hit = ({1'b0, rd_idx} < 9'(PALETTE_DEPTH)) && pal_valid_reg[rd_idx[PIDX_W-1:0]];
    end

    // Palette memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pal_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= pal_mem[rd_idx[PIDX_W-1:0]];
        rd_ok_reg   <= rd_hit;
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_ch.valid && byte_ch.ready) |=> !byte_ch.ready)
        else $error("input taken again right after a transaction");

    a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_ch.valid && pixel_ch.data.image_end) |-> pixel_ch.data.row_end)
        else $error("image end without row end");

    a_row_end_closes_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_ch.valid && pixel_ch.data.row_end) |-> pixel_ch.data.last_of_item)
        else $error("row end not marked as last pixel of its byte");

    a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUT))
        else $error("output loaded outside the emit step");

endmodule

[tb/tb_bitmap_pixel_row_unpacker_core.sv]
// Self-checking testbench for the bitmap pixel row unpacker core.
`timescale 1ns / 100ps

module tb_bitmap_pixel_row_unpacker_core;
    import bpu_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int PAL_DEPTH     = 256;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 130;

    typedef enum logic [1:0] {
        ST_PALETTE,
        ST_ROWS,
        ST_DONE
    } unpack_stage_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bpu_byte_if  byte_ch ();
    bpu_pixel_if pixel_ch ();

    bitmap_pixel_row_unpacker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_ch   (byte_ch),
        .pixel_ch  (pixel_ch)
    );

    always #5 clk = ~clk;

    // Register copies
    pixel_format_t fmt_reg       = FMT_1BPP;
    int            width_reg     = 1;
    int            height_reg    = 1;
    int            pal_count_reg = 0;

    // Unpacker state copies
    unpack_stage_t stage          = ST_PALETTE;
    int            entries_loaded = 0;
    logic [23:0]   palette_mem [PAL_DEPTH] = '{default: 24'h0};
    logic [15:0]   partial        = '0;
    int            byte_in_row    = 0;
    int            pixel_in_row   = 0;
    int            row_index      = 0;

    pixel_item_t pixels_due [$];
    int          err_count    = 0;
    bit          idling       = 1'b1;
    bit          hold_request = 1'b0;

    // Zero width or height counts as one, large values saturate
    function automatic int clamp_dim(input int v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // Bytes of pixel data in one row, before padding
    function automatic int row_data_bytes(input pixel_format_t f, input int w);
        case (f)
            FMT_1BPP: return (w + 7) / 8;
            FMT_4BPP: return (w + 1) / 2;
            FMT_8BPP: return w;
            default:  return 3 * w;
        endcase
    endfunction

    task automatic push_pixel(input logic [23:0] rgb, input int w, input int h);
        pixel_item_t p;
        pixel_in_row++;
        p.red          = rgb[23:16];
        p.green        = rgb[15:8];
        p.blue         = rgb[7:0];
        p.row_end      = (pixel_in_row >= w);
        p.image_end    = p.row_end && (row_index + 1 >= h);
        p.last_of_item = 1'b0;
        pixels_due.push_back(p);
    endtask

    // Expected pixels for one accepted byte
    task automatic unpack_byte(input logic [7:0] value, input logic start);
        int w, h, data_len, padded, due_before, k;
        due_before = pixels_due.size();
        if (start)
        begin
            stage          = ST_PALETTE;
            entries_loaded = 0;
            partial        = '0;
            byte_in_row    = 0;
            pixel_in_row   = 0;
            row_index      = 0;
        end
        if (stage == ST_PALETTE)
        begin
            if (entries_loaded >= pal_count_reg)
            begin
                // palette complete: this byte is already pixel data
                stage       = ST_ROWS;
                byte_in_row = 0;
                partial     = '0;
            end
            else
            begin
                // entry bytes: blue, green, red, spare
                case (byte_in_row)
                    0: partial = {8'h00, value};
                    1: partial = {partial[7:0], value};
                    2:
                    begin
                        if (entries_loaded < PAL_DEPTH)
                            palette_mem[entries_loaded] = {value, partial[7:0], partial[15:8]};
                    end
                    default: entries_loaded++;
                endcase
                byte_in_row = (byte_in_row + 1) % 4;
                return;
            end
        end
        if (stage != ST_ROWS)
            return;

        w        = clamp_dim(width_reg);
        h        = clamp_dim(height_reg);
        data_len = row_data_bytes(fmt_reg, w);
        padded   = (data_len + 3) / 4 * 4;

        if (byte_in_row < data_len)
        begin
            case (fmt_reg)
                FMT_1BPP:
                begin
                    for (k = 7; k >= 0 && pixel_in_row < w; k--)
                        push_pixel(palette_mem[value[k]], w, h);
                end
                FMT_4BPP:
                begin
                    if (pixel_in_row < w)
                        push_pixel(palette_mem[value[7:4]], w, h);
                    if (pixel_in_row < w)
                        push_pixel(palette_mem[value[3:0]], w, h);
                end
                FMT_8BPP:
                begin
                    if (pixel_in_row < w)
                        push_pixel(palette_mem[value], w, h);
                end
                default:
                begin
                    // blue, green, red triple
                    case (byte_in_row % 3)
                        0: partial = {8'h00, value};
                        1: partial = {partial[7:0], value};
                        default:
                        begin
                            if (pixel_in_row < w)
                                push_pixel({value, partial[7:0], partial[15:8]}, w, h);
                        end
                    endcase
                end
            endcase
        end

        // padded row length reached: next row
        byte_in_row++;
        if (byte_in_row >= padded)
        begin
            byte_in_row  = 0;
            pixel_in_row = 0;
            row_index++;
            if (row_index >= h)
                stage = ST_DONE;
        end
        if (pixels_due.size() > due_before)
            pixels_due[pixels_due.size() - 1].last_of_item = 1'b1;
    endtask

    // Register write; only while the block is idle
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_PIXEL_FORMAT: fmt_reg    = pixel_format_t'(value[1:0]);
            CFG_IMAGE_WIDTH:  width_reg  = value;
            CFG_IMAGE_HEIGHT: height_reg = value;
            default:          pal_count_reg = value[8:0];
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One byte transaction, with an occasional gap before it while idling is set
    task automatic send_byte(input logic [7:0] value, input logic start);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data  <= {value, start};
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        unpack_byte(value, start);
    endtask

    task automatic send_run(input int count, input bit start_first);
        int i;
        for (i = 0; i < count; i++)
            send_byte(8'($urandom), start_first && i == 0);
    endtask

    // Stop sending, wait for every pixel, then let the block go idle
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want_v, got_v);
            err_count++;
        end
    endtask

    // Reset defaults: 1 bit, width 1, height 1, empty palette, store still zero
    task automatic test_defaults();
        send_byte(8'h80, 1'b1);
        send_run(3, 1'b0);
        send_byte(8'hFF, 1'b0);
        settle();
    endtask

    // Each pixel format, rows start with all ones or all zeros
    task automatic test_each_format();
        int i, r, b, row_len, pal;
        int pal_sizes [4];
        pixel_format_t f;
        pal_sizes = '{2, 4, 3, 0};
        for (i = 0; i < 4; i++)
        begin
            f   = pixel_format_t'(i);
            pal = pal_sizes[i];
            write_reg(CFG_PIXEL_FORMAT, 13'(f));
            write_reg(CFG_IMAGE_WIDTH, 13'd5);
            write_reg(CFG_IMAGE_HEIGHT, 13'd2);
            write_reg(CFG_PALETTE_COUNT, 13'(pal));
            if (pal > 0)
                send_run(pal * 4, 1'b1);
            row_len = (row_data_bytes(f, 5) + 3) / 4 * 4;
            for (r = 0; r < 2; r++)
                for (b = 0; b < row_len; b++)
                    send_byte((b == 0) ? ((r == 0) ? 8'hFF : 8'h00) : 8'($urandom),
                              pal == 0 && r == 0 && b == 0);
            settle();
        end
    endtask

    // Zero sizes, then saturated width and saturated height
    task automatic test_dim_extremes();
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_24BPP));
        write_reg(CFG_IMAGE_WIDTH, 13'd0);
        write_reg(CFG_IMAGE_HEIGHT, 13'd0);
        write_reg(CFG_PALETTE_COUNT, 13'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_run(3, 1'b0);
        settle();

        // start of a saturated row: no row end yet
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_1BPP));
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        send_run(8, 1'b1);
        settle();

        // first rows of a saturated image: no image end yet
        write_reg(CFG_IMAGE_WIDTH, 13'd1);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        send_run(12, 1'b1);
        settle();
    endtask

    // Largest palette count, cut short, then a short reload over it
    task automatic test_palette_overflow();
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_8BPP));
        write_reg(CFG_IMAGE_WIDTH, 13'd8);
        write_reg(CFG_IMAGE_HEIGHT, 13'd1);
        write_reg(CFG_PALETTE_COUNT, 13'h1FF);
        send_run(10 * 4, 1'b1);
        settle();

        // short reload: higher entries keep their earlier contents
        write_reg(CFG_PALETTE_COUNT, 13'd2);
        send_run(8, 1'b1);
        send_byte(8'h09, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_run(4, 1'b0);
        settle();
    endtask

    // Receiver holds off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_1BPP));
        write_reg(CFG_IMAGE_WIDTH, 13'd64);
        write_reg(CFG_IMAGE_HEIGHT, 13'd2);
        write_reg(CFG_PALETTE_COUNT, 13'd0);
        send_byte(8'($urandom), 1'b1);
        hold_request = 1'b1;
        send_run(15, 1'b0);
        settle();
    endtask

    // Registers changed inside an image, then a frame start mid-row
    task automatic test_mid_image_changes();
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_8BPP));
        write_reg(CFG_IMAGE_WIDTH, 13'd8);
        write_reg(CFG_IMAGE_HEIGHT, 13'd3);
        send_run(6, 1'b1);
        settle();
        // row position now past the shorter row
        write_reg(CFG_IMAGE_WIDTH, 13'd3);
        send_run(3, 1'b0);
        settle();
        write_reg(CFG_PIXEL_FORMAT, 13'(FMT_24BPP));
        send_run(14, 1'b0);
        send_byte(8'($urandom), 1'b1);
        send_run(5, 1'b0);
        settle();
    endtask

    // Random images: mostly well formed, some cut short, restarted or noise
    task automatic test_random_images();
        int produced, w, h, pal, total, cut, mode, i;
        pixel_format_t f;
        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            idling = (produced < RANDOM_ITEMS - 60);
            f = pixel_format_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                w = $urandom_range(0, 2);
            else
                w = $urandom_range(1, (f == FMT_24BPP) ? 12 : 40);
            h = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       pal = 0;
                1:       pal = 2;
                2:       pal = 16;
                default: pal = $urandom_range(1, 8);
            endcase
            write_reg(CFG_PIXEL_FORMAT, {11'($urandom), 2'(f)});
            write_reg(CFG_IMAGE_WIDTH, 13'(w));
            write_reg(CFG_IMAGE_HEIGHT, 13'(h));
            write_reg(CFG_PALETTE_COUNT, {4'($urandom), 9'(pal)});
            total = pal * 4 + (row_data_bytes(f, clamp_dim(w)) + 3) / 4 * 4 * clamp_dim(h);
            mode  = $urandom_range(0, 9);
            if (mode == 9)
            begin
                // noise with stray frame starts
                total = 12;
                for (i = 0; i < total; i++)
                    send_byte(8'($urandom), $urandom_range(0, 5) == 0);
            end
            else
            begin
                cut = (mode >= 7) ? $urandom_range(1, total - 1) : total;
                for (i = 0; i < total && !(mode == 7 && i == cut); i++)
                    send_byte(8'($urandom), i == 0 || (mode == 8 && i == cut));
                if (mode == 7)
                    total = cut;
                else
                    send_run($urandom_range(0, 3), 1'b0);
            end
            produced += total;
            settle();
        end
    endtask

    // Receiver: checks each pixel transaction, drives ready with stalls
    int          stall_left = 0;
    int          hold_left  = 0;
    pixel_item_t got_px, want_px;

    initial
    begin
        pixel_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixel_ch.valid && pixel_ch.ready)
            begin
                got_px = pixel_ch.data;
                if (pixels_due.size() == 0)
                begin
                    $display("%0t: unexpected pixel: expected none, actual %p", $time, got_px);
                    err_count++;
                end
                else
                begin
                    want_px = pixels_due.pop_front();
                    check_field("red", want_px.red, got_px.red);
                    check_field("green", want_px.green, got_px.green);
                    check_field("blue", want_px.blue, got_px.blue);
                    check_field("row_end", want_px.row_end, got_px.row_end);
                    check_field("image_end", want_px.image_end, got_px.image_end);
                    check_field("last_of_item", want_px.last_of_item, got_px.last_of_item);
                end
            end
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (!rst_n)
            begin
                pixel_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                pixel_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pixel_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                pixel_ch.ready <= 1'b0;
            end
            else
            begin
                pixel_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction or register write
    int quiet_cycles = 0;

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
                || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        byte_ch.valid = 1'b0;
        byte_ch.data  = '0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_PIXEL_FORMAT;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_each_format();
        test_dim_extremes();
        test_palette_overflow();
        test_backpressure();
        test_mid_image_changes();
        test_random_images();
        settle();

        if (err_count == 0 && pixels_due.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("%0t: %0d errors, %0d pixels missing", $time, err_count, pixels_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bpu_pkg.sv
rtl/bpu_byte_if.sv
rtl/bpu_pixel_if.sv
rtl/bitmap_pixel_row_unpacker_core.sv
tb/tb_bitmap_pixel_row_unpacker_core.sv
